>>> hw/rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the one-wire bus master: phase codes, command
// and status codes, register indexes, reset values and the transaction types.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned SHOW_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_HOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_REST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_REST     = 3'd7;

  localparam logic [1:0] OP_RESET     = 2'd0;
  localparam logic [1:0] OP_WRITE     = 2'd1;
  localparam logic [1:0] OP_READ_BYTE = 2'd2;
  localparam logic [1:0] OP_READ_WORD = 2'd3;

  localparam logic [1:0] DRV_RELEASE = 2'd0;
  localparam logic [1:0] DRV_LOW     = 2'd1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_PRESENCE = 2'd1;
  localparam logic [1:0] ST_STUCK_LOW   = 2'd2;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_RST_LOW   = 3'd1;
  localparam logic [2:0] PH_RST_WAIT  = 3'd2;
  localparam logic [2:0] PH_RST_HOLD  = 3'd3;
  localparam logic [2:0] PH_SLOT_LOW  = 3'd4;
  localparam logic [2:0] PH_SLOT_REL  = 3'd5;
  localparam logic [2:0] PH_SLOT_REST = 3'd6;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [7:0] presence_wait_us;
    logic [9:0] presence_hold_us;
    logic [5:0] short_low_us;
    logic [6:0] write_one_rest_us;
    logic [6:0] write_zero_low_us;
    logic [5:0] read_sample_us;
    logic [6:0] read_rest_us;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low_us:      10'd480,
    presence_wait_us:  8'd40,
    presence_hold_us:  10'd300,
    short_low_us:      6'd5,
    write_one_rest_us: 7'd56,
    write_zero_low_us: 7'd60,
    read_sample_us:    6'd10,
    read_rest_us:      7'd46
  };

  typedef struct packed {
    logic       start_req;
    logic [1:0] opcode;
    logic [7:0] write_data;
    logic       line_in;
  } item_t;

  typedef struct packed {
    logic [1:0]        line_drive;
    logic              busy_res;
    logic              done_res;
    logic [SHOW_W-1:0] read_data;
    logic [1:0]        reset_status;
  } res_t;

  function automatic logic [TICK_W-1:0] dur(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

>>> hw/rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master stepped by microsecond ticks, with queues on both sides.
// ----------------------------------------------------------------------------
// Each transaction pushed on the input side is one microsecond tick carrying
// the sampled bus level and, optionally, a command request (reset with
// presence check, byte write, byte read or word read). Each tick yields one
// result transaction on the output side: line drive, busy, done, the last read
// data and the last reset status. Configuration writes set the slot and reset
// durations; the user must make them only while no tick is in flight, as the
// block itself does not enforce this. A tick is accepted when push is high and
// full is low. It passes a two-entry input queue, is processed by the bus
// engine and lands in a two-entry result queue. The engine takes one tick per
// cycle when the input queue is not empty and the result queue is not full;
// it sustains one transaction per cycle while the consumer pops every cycle.
// When the consumer stalls, the result queue fills, the engine holds its state
// and the input queue then raises full. Synchronous reset empties both queues,
// returns the engine to idle and loads the default durations.
// ----------------------------------------------------------------------------
module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_start_req,
  input  logic [1:0]            in_opcode,
  input  logic [7:0]            in_write_data,
  input  logic                  in_line_in,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            out_line_drive,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic [SHOW_W-1:0]     out_read_data,
  output logic [1:0]            out_reset_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  item_t in_item, eng_item;
  res_t  eng_res, out_res;
  logic  in_empty, out_full, step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:      cfg_r.reset_low_us      <= cfg_data;
        REG_PRESENCE_WAIT:  cfg_r.presence_wait_us  <= cfg_data[7:0];
        REG_PRESENCE_HOLD:  cfg_r.presence_hold_us  <= cfg_data;
        REG_SHORT_LOW:      cfg_r.short_low_us      <= cfg_data[5:0];
        REG_WRITE_ONE_REST: cfg_r.write_one_rest_us <= cfg_data[6:0];
        REG_WRITE_ZERO_LOW: cfg_r.write_zero_low_us <= cfg_data[6:0];
        REG_READ_SAMPLE:    cfg_r.read_sample_us    <= cfg_data[5:0];
        REG_READ_REST:      cfg_r.read_rest_us      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{
    start_req:  in_start_req,
    opcode:     in_opcode,
    write_data: in_write_data,
    line_in:    in_line_in
  };

  assign step = !in_empty && !out_full;

  owbm_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (2)
  ) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (in_item),
    .full    (full),
    .rd_en   (step),
    .rd_data (eng_item),
    .empty   (in_empty)
  );

  owbm_engine #(
    .WORD_BITS (WORD_BITS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg_r),
    .item  (eng_item),
    .res   (eng_res)
  );

  owbm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (step),
    .wr_data (eng_res),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign out_line_drive   = out_res.line_drive;
  assign out_busy_res     = out_res.busy_res;
  assign out_done_res     = out_res.done_res;
  assign out_read_data    = out_res.read_data;
  assign out_reset_status = out_res.reset_status;

endmodule

>>> hw/rtl/owbm_fifo.sv
// ----------------------------------------------------------------------------
// owbm_fifo
// Small synchronous queue used on both sides of the bus engine.
// ----------------------------------------------------------------------------
module owbm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/owbm_engine.sv
// ----------------------------------------------------------------------------
// owbm_engine
// Bus engine: advances the reset and slot sequencer by one tick per step and
// forms that tick's result.
// ----------------------------------------------------------------------------
module owbm_engine
  import owbm_pkg::*;
#(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  cfg_t  cfg,
  input  item_t item,
  output res_t  res
);

  localparam int unsigned BL_W = $clog2(WORD_BITS + 1);
  localparam int unsigned KEEP = (WORD_BITS < SHOW_W) ? WORD_BITS : SHOW_W;

  logic [2:0]           phase_r, phase_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic [BL_W-1:0]      bits_r, bits_nxt;
  logic [WORD_BITS-1:0] shift_r, shift_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [SHOW_W-1:0]    hold_r, hold_nxt;
  logic [1:0]           drive;
  logic                 busy, done, slot_end;

  function automatic logic [TICK_W-1:0] slot_low(input logic [1:0] k, input logic b0,
                                                  input cfg_t c);
    return (k == OP_WRITE && !b0) ? dur(TICK_W'(c.write_zero_low_us))
                                  : dur(TICK_W'(c.short_low_us));
  endfunction

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    tick_nxt   = tick_r;
    bits_nxt   = bits_r;
    shift_nxt  = shift_r;
    status_nxt = status_r;
    hold_nxt   = hold_r;
    drive      = DRV_RELEASE;
    busy       = 1'b0;
    done       = 1'b0;
    slot_end   = 1'b0;

    if (phase_nxt == PH_IDLE && item.start_req) begin
      kind_nxt = item.opcode;
      if (kind_nxt == OP_RESET) begin
        phase_nxt = PH_RST_LOW;
        tick_nxt  = dur(cfg.reset_low_us);
      end else begin
        shift_nxt = (kind_nxt == OP_WRITE) ? WORD_BITS'(item.write_data) : '0;
        bits_nxt  = (kind_nxt == OP_READ_WORD) ? BL_W'(WORD_BITS) : BL_W'(8);
        phase_nxt = PH_SLOT_LOW;
        tick_nxt  = slot_low(kind_nxt, shift_nxt[0], cfg);
      end
    end

    if (phase_nxt != PH_IDLE) begin
      busy  = 1'b1;
      drive = (phase_nxt == PH_RST_LOW || phase_nxt == PH_SLOT_LOW) ? DRV_LOW : DRV_RELEASE;
      if (tick_nxt != '0) begin
        tick_nxt = tick_nxt - TICK_W'(1);
      end
      if (tick_nxt == '0) begin
        unique case (phase_nxt)
          PH_RST_LOW: begin
            phase_nxt = PH_RST_WAIT;
            tick_nxt  = dur(TICK_W'(cfg.presence_wait_us));
          end
          PH_RST_WAIT: begin
            if (item.line_in) begin
              status_nxt = ST_NO_PRESENCE;
              phase_nxt  = PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_nxt = PH_RST_HOLD;
              tick_nxt  = dur(cfg.presence_hold_us);
            end
          end
          PH_RST_HOLD: begin
            status_nxt = item.line_in ? ST_OK : ST_STUCK_LOW;
            phase_nxt  = PH_IDLE;
            done       = 1'b1;
          end
          PH_SLOT_LOW: begin
            phase_nxt = PH_SLOT_REL;
            if (kind_nxt == OP_WRITE) begin
              tick_nxt = shift_nxt[0] ? dur(TICK_W'(cfg.write_one_rest_us)) : TICK_W'(1);
            end else begin
              tick_nxt = dur(TICK_W'(cfg.read_sample_us));
            end
          end
          PH_SLOT_REL: begin
            if (kind_nxt == OP_WRITE) begin
              slot_end = 1'b1;
            end else begin
              shift_nxt = shift_nxt >> 1;
              if (item.line_in) begin
                if (kind_nxt == OP_READ_WORD) begin
                  shift_nxt[WORD_BITS-1] = 1'b1;
                end else begin
                  shift_nxt[7] = 1'b1;
                end
              end
              phase_nxt = PH_SLOT_REST;
              tick_nxt  = dur(TICK_W'(cfg.read_rest_us));
            end
          end
          default: begin
            slot_end = 1'b1;
          end
        endcase

        if (slot_end) begin
          if (kind_nxt == OP_WRITE) begin
            shift_nxt = shift_nxt >> 1;
          end
          if (bits_nxt != '0) begin
            bits_nxt = bits_nxt - BL_W'(1);
          end
          if (bits_nxt == '0) begin
            if (kind_nxt != OP_WRITE) begin
              hold_nxt = SHOW_W'(shift_nxt[KEEP-1:0]);
            end
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_SLOT_LOW;
            tick_nxt  = slot_low(kind_nxt, shift_nxt[0], cfg);
          end
        end
      end
    end
  end

  assign res = '{
    line_drive:   drive,
    busy_res:     busy,
    done_res:     done,
    read_data:    hold_nxt,
    reset_status: status_nxt
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      kind_r   <= '0;
      tick_r   <= '0;
      bits_r   <= '0;
      shift_r  <= '0;
      status_r <= ST_OK;
      hold_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      tick_r   <= tick_nxt;
      bits_r   <= bits_nxt;
      shift_r  <= shift_nxt;
      status_r <= status_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule
